FILE: rtl/kct_pkg.sv
package kct_pkg;

	// Table size and iterate limit.
	localparam int CAPACITY     = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int ITER_LIMIT   = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;

	// Field widths.
	localparam int KEY_W  = 31;
	localparam int CNT_W  = 31;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;

	// Index into the store, and a fill count that can also hold CAPACITY itself.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W = $clog2(CAPACITY + 1);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GET  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ITER = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZERO_KEY = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

	// One result beat.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  count;
		logic [STAT_W-1:0] status;
		logic              last;
	} result_t;

	// Write request into the key and count store.
	typedef struct packed {
		logic              key_en;
		logic              cnt_en;
		logic [IDX_W-1:0]  addr;
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  count;
	} store_wr_t;

endpackage

FILE: rtl/kct_store.sv
module kct_store (
	input  logic                     clk,
	input  kct_pkg::store_wr_t       wr,
	input  logic                     rd_en,
	input  logic [kct_pkg::IDX_W-1:0] rd_addr,
	output logic [kct_pkg::KEY_W-1:0] rd_key,
	output logic [kct_pkg::CNT_W-1:0] rd_count
);

	logic [kct_pkg::KEY_W-1:0] key_mem [kct_pkg::CAPACITY];
	logic [kct_pkg::CNT_W-1:0] cnt_mem [kct_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.key_en) begin
			key_mem[wr.addr] <= wr.key;
		end
		if (wr.cnt_en) begin
			cnt_mem[wr.addr] <= wr.count;
		end
	end

	// Read data is registered and holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key   <= key_mem[rd_addr];
			rd_count <= cnt_mem[rd_addr];
		end
	end

endmodule

FILE: rtl/kct_seq.sv
module kct_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [kct_pkg::MODE_W-1:0]  mode,
	input  logic [kct_pkg::KEY_W-1:0]   key,
	input  logic [kct_pkg::CNT_W-1:0]   set_value,
	input  logic                        out_free,
	output logic                        push,
	output kct_pkg::result_t            push_res,
	output kct_pkg::store_wr_t          wr,
	output logic                        rd_en,
	output logic [kct_pkg::IDX_W-1:0]   rd_addr,
	input  logic [kct_pkg::KEY_W-1:0]   rd_key,
	input  logic [kct_pkg::CNT_W-1:0]   rd_count
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_EMIT     = 3'd2;
	localparam logic [2:0] S_ITR_RD   = 3'd3;
	localparam logic [2:0] S_ITR_EMIT = 3'd4;

	localparam logic [kct_pkg::OCC_W-1:0] CAP_C   = kct_pkg::OCC_W'(kct_pkg::CAPACITY);
	localparam logic [kct_pkg::OCC_W-1:0] LIMIT_C = kct_pkg::OCC_W'(kct_pkg::ITER_LIMIT);

	logic [2:0]                    state_q, state_d;
	logic [kct_pkg::OCC_W-1:0]     occ_q, occ_d;
	logic [kct_pkg::OCC_W-1:0]     ptr_q, ptr_d;
	logic                          pend_q, pend_d;
	logic [kct_pkg::IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
	logic [kct_pkg::MODE_W-1:0]    mode_q;
	logic [kct_pkg::KEY_W-1:0]     key_q;
	logic [kct_pkg::CNT_W-1:0]     val_q;
	kct_pkg::result_t              res_q, res_d;

	logic                          match;
	logic                          issue;
	logic [kct_pkg::CNT_W-1:0]     hit_count;
	logic [kct_pkg::OCC_W-1:0]     iter_n;
	logic                          iter_last;

	assign in_ready = (state_q == S_IDLE);

	// The shared compare unit: one stored key against the search key per cycle.
	assign match = pend_q && (rd_key == key_q);
	assign issue = (ptr_q < occ_q);

	always_comb begin
		unique case (mode_q)
			kct_pkg::MODE_ADD:
				hit_count = (rd_count == kct_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1;
			kct_pkg::MODE_SET:
				hit_count = val_q;
			default:
				hit_count = rd_count;
		endcase
	end

	assign iter_n    = (occ_q > LIMIT_C) ? LIMIT_C : occ_q;
	assign iter_last = ((ptr_q + 1'b1) == iter_n);

	always_comb begin
		state_d   = state_q;
		occ_d     = occ_q;
		ptr_d     = ptr_q;
		pend_d    = pend_q;
		cmp_idx_d = cmp_idx_q;
		res_d     = res_q;
		push      = 1'b0;
		push_res  = res_q;
		rd_en     = 1'b0;
		rd_addr   = ptr_q[kct_pkg::IDX_W-1:0];
		wr        = '0;
		wr.key    = key_q;
		wr.count  = hit_count;
		wr.addr   = cmp_idx_q;

		unique case (state_q)
			S_IDLE: begin
				ptr_d  = '0;
				pend_d = 1'b0;
				if (in_valid) begin
					if (mode == kct_pkg::MODE_ITER) begin
						if (occ_q == '0) begin
							res_d   = '{key: '0, count: '0, status: kct_pkg::ST_EMPTY, last: 1'b1};
							state_d = S_EMIT;
						end else begin
							state_d = S_ITR_RD;
						end
					end else if (key == '0) begin
						res_d   = '{key: '0, count: '0, status: kct_pkg::ST_ZERO_KEY, last: 1'b1};
						state_d = S_EMIT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (match) begin
					wr.cnt_en = (mode_q != kct_pkg::MODE_GET);
					res_d     = '{key: key_q, count: hit_count, status: kct_pkg::ST_OK, last: 1'b1};
					state_d   = S_EMIT;
				end else if (!pend_q && !issue) begin
					// Every stored key has been compared without a hit.
					state_d = S_EMIT;
					if (mode_q == kct_pkg::MODE_GET) begin
						res_d = '{key: key_q, count: '0, status: kct_pkg::ST_OK, last: 1'b1};
					end else if (occ_q == CAP_C) begin
						res_d = '{key: key_q, count: '0, status: kct_pkg::ST_FULL, last: 1'b1};
					end else begin
						wr.key_en = 1'b1;
						wr.cnt_en = 1'b1;
						wr.addr   = occ_q[kct_pkg::IDX_W-1:0];
						wr.count  = (mode_q == kct_pkg::MODE_ADD) ? kct_pkg::CNT_W'(1) : val_q;
						res_d     = '{key: key_q, count: wr.count, status: kct_pkg::ST_OK,
							last: 1'b1};
						occ_d     = occ_q + 1'b1;
					end
				end else begin
					rd_en     = issue;
					pend_d    = issue;
					cmp_idx_d = ptr_q[kct_pkg::IDX_W-1:0];
					if (issue) begin
						ptr_d = ptr_q + 1'b1;
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ITR_RD: begin
				rd_en   = 1'b1;
				state_d = S_ITR_EMIT;
			end
			S_ITR_EMIT: begin
				push_res = '{key: rd_key, count: rd_count, status: kct_pkg::ST_OK, last: iter_last};
				if (out_free) begin
					push  = 1'b1;
					ptr_d = ptr_q + 1'b1;
					state_d = iter_last ? S_IDLE : S_ITR_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			ptr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			ptr_q   <= ptr_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= cmp_idx_d;
		res_q     <= res_d;
		if (in_valid && in_ready) begin
			mode_q <= mode;
			key_q  <= key;
			val_q  <= set_value;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CAP_C)
		else $error("fill count beyond table capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed while output register is occupied");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> ((occ_q == $past(occ_q) + 1'b1) && ($past(state_q) == S_SCAN)))
		else $error("fill count moved other than by one insertion");

	a_scan_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (ptr_q <= occ_q))
		else $error("scan pointer ran past the stored entries");

endmodule

FILE: rtl/key_count_table.sv
// Key and count table: add, set, get and iterate over up to CAPACITY key and count pairs.
// Add, set and get: one beat, registered after acceptance; the single key comparator scans stored
// entries one per cycle, so a miss is slowest; key zero is quickest, as it is rejected unscanned.
// Iterate: a read, then an emit, per stored pair, at most sixteen beats.
// One item at a time; a new item is taken the cycle after its last beat enters the output
// register. Reset (arst_n low) empties the table and drops any pending beat.
module key_count_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [kct_pkg::MODE_W-1:0]  mode,
	input  logic [kct_pkg::KEY_W-1:0]   key,
	input  logic [kct_pkg::CNT_W-1:0]   set_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kct_pkg::KEY_W-1:0]   entry_key,
	output logic [kct_pkg::CNT_W-1:0]   entry_count,
	output logic [kct_pkg::STAT_W-1:0]  status,
	output logic                        last
);

	// Handshake between the sequencer and the output register.
	logic                        out_free;
	logic                        push;
	kct_pkg::result_t            push_res;

	// Store access.
	kct_pkg::store_wr_t          wr;
	logic                        rd_en;
	logic [kct_pkg::IDX_W-1:0]   rd_addr;
	logic [kct_pkg::KEY_W-1:0]   rd_key;
	logic [kct_pkg::CNT_W-1:0]   rd_count;

	// Output register.
	logic                        out_valid_q;
	kct_pkg::result_t            out_q;

	// The sequencer owns the fill count and walks the store for each operation.
	kct_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.key      (key),
		.set_value(set_value),
		.out_free (out_free),
		.push     (push),
		.push_res (push_res),
		.wr       (wr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_count (rd_count)
	);

	// Entries are only ever read below the fill count, so the store needs no clearing.
	kct_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_count(rd_count)
	);

	// The output register may take a new beat when it is empty or is being drained this cycle.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset; it is only looked at while the valid flag is set.
	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_key   = out_q.key;
	assign entry_count = out_q.count;
	assign status      = out_q.status;
	assign last        = out_q.last;

endmodule
